// File: hw/rtl/cbal_pkg.sv
// Shared types and constants for the cubic Bezier arc length unit.
// No dependencies.
`timescale 1ns / 1ps

package cbal_pkg;

    localparam int COORD_W = 24;
    localparam int T_W     = 17;
    localparam int WGT_W   = 31;
    localparam int PNT_W   = 27;
    localparam int SQ_W    = 56;
    localparam int RT_W    = SQ_W / 2 + 1;
    localparam int ACC_W   = 40;
    localparam int LEN_W   = 32;

    localparam logic [T_W-1:0]     T_ONE     = 17'h10000;
    localparam logic [COORD_W-1:0] COORD_BIAS = 24'h800000;
    localparam logic [ACC_W-1:0]   LEN_MAX   = 40'h00_FFFF_FFFF;

    typedef struct packed {
        logic [COORD_W-1:0] ox;
        logic [COORD_W-1:0] oy;
        logic [COORD_W-1:0] tx;
        logic [COORD_W-1:0] ty;
        logic [COORD_W-1:0] cx;
    } t_item;

    typedef struct packed {
        t_item item;
        logic  first;
        logic  last;
    } t_tok;

endpackage

// File: hw/rtl/cubic_bezier_arc_length_unit.sv
// Cubic Bezier arc length unit, top level.
// Depends on cbal_pkg, cbal_front, cbal_queue, cbal_back.
//
// Slave channel s_axis carries one curve per transfer: origin and target
// points in signed Q16.8. The curve runs from the origin through two
// control points at the mean x, at the origin's y and at the target's y.
// Master channel m_axis returns one transfer per curve: the summed length
// of SEGMENTS chords in unsigned Q24.8, saturating, and a saturation flag.
// The sequencer issues SEGMENTS samples per curve, one sample per cycle
// while the master side does not stall, into the evaluation pipeline,
// which is the limiting unit. Curves follow each other with no gap while
// the four-entry queue holds work. A curve passes the input stage, queue,
// sequencer, weight and point pipeline, chord length, pipelined square
// root, accumulator and output register.
// Reset (synchronous, active low) empties the input stage, the queue and
// the pipeline. A stalled master side freezes the whole back end, holding
// the pending result; the queue then fills and s_axis_tready drops.
`timescale 1ns / 1ps

module cubic_bezier_arc_length_unit import cbal_pkg::*; #(
    parameter int SEGMENTS = 100
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [95:0] s_axis_tdata,   // origin_x, origin_y, target_x, target_y
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // curve_length
    output logic        m_axis_tuser    // length_saturated
);

    logic  f_valid, q_full, q_pop, q_valid;
    t_item f_item, q_item;

    cbal_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_data  (s_axis_tdata),
        .o_valid (f_valid),
        .i_ready (!q_full),
        .o_item  (f_item)
    );

    cbal_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_valid && !q_full),
        .i_item  (f_item),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    cbal_back #(
        .SEGMENTS (SEGMENTS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_item  (q_item),
        .o_q_pop   (q_pop),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_len     (m_axis_tdata),
        .o_sat     (m_axis_tuser)
    );

endmodule

// File: hw/rtl/cbal_front.sv
// Input stage: takes a transfer, biases the coordinates, forms control x.
// Depends on cbal_pkg.
`timescale 1ns / 1ps

module cbal_front import cbal_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [95:0] i_data,
    output logic        o_valid,
    input  logic        i_ready,
    output t_item       o_item
);

    logic  r_valid;
    t_item r_item;
    t_item n_item;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_comb begin
        n_item.ox = i_data[23:0]  ^ COORD_BIAS;
        n_item.oy = i_data[47:24] ^ COORD_BIAS;
        n_item.tx = i_data[71:48] ^ COORD_BIAS;
        n_item.ty = i_data[95:72] ^ COORD_BIAS;
        n_item.cx = 24'(({1'b0, n_item.ox} + {1'b0, n_item.tx}) >> 1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= n_item;
        end
    end

endmodule

// File: hw/rtl/cbal_queue.sv
// Four-entry queue of items between front and back.
// Depends on cbal_pkg.
`timescale 1ns / 1ps

module cbal_queue import cbal_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_valid,
    output t_item o_item
);

    t_item      r_mem [4];
    logic [1:0] r_wr;
    logic [1:0] r_rd;
    logic [2:0] r_cnt;

    assign o_full  = r_cnt == 3'd4;
    assign o_valid = r_cnt != 3'd0;
    assign o_item  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 2'd0;
            r_rd  <= 2'd0;
            r_cnt <= 3'd0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 2'd1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 2'd1;
            end
            r_cnt <= r_cnt + 3'(i_push) - 3'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

endmodule

// File: hw/rtl/cbal_sqrt.sv
// Pipelined rounded square root, one result bit per stage.
// Depends on cbal_pkg.
`timescale 1ns / 1ps

module cbal_sqrt import cbal_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  logic            i_last,
    input  logic [SQ_W-1:0] i_val,
    output logic            o_valid,
    output logic            o_last,
    output logic [RT_W-1:0] o_root
);

    localparam int N = SQ_W / 2;

    logic [SQ_W-1:0] r_v    [N+1];
    logic [SQ_W-1:0] r_r    [N+1];
    logic            r_vld  [N+1];
    logic            r_lst  [N+1];
    logic            r_ovld;
    logic            r_olst;
    logic [RT_W-1:0] r_root;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_v[0]   <= i_val;
            r_r[0]   <= '0;
            r_lst[0] <= i_last;
        end
    end

    for (genvar k = 0; k < N; k++) begin : g_stage
        localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (SQ_W - 2 - 2 * k);
        logic [SQ_W-1:0] trial;
        assign trial = r_r[k] + BIT;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[k+1] <= r_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_lst[k+1] <= r_lst[k];
                if (r_v[k] >= trial) begin
                    r_v[k+1] <= r_v[k] - trial;
                    r_r[k+1] <= (r_r[k] >> 1) + BIT;
                end else begin
                    r_v[k+1] <= r_v[k];
                    r_r[k+1] <= r_r[k] >> 1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (i_en) begin
            r_ovld <= r_vld[N];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_olst <= r_lst[N];
            r_root <= RT_W'(r_r[N]) + RT_W'(r_v[N] > r_r[N]);
        end
    end

    assign o_valid = r_ovld;
    assign o_last  = r_olst;
    assign o_root  = r_root;

endmodule

// File: hw/rtl/cbal_back.sv
// Back end: sample sequencer, Bezier evaluation pipeline, segment length,
// length accumulation and output register. Depends on cbal_pkg, cbal_sqrt.
`timescale 1ns / 1ps

module cbal_back import cbal_pkg::*; #(
    parameter int SEGMENTS = 100
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    input  t_item            i_q_item,
    output logic             o_q_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [LEN_W-1:0] o_len,
    output logic             o_sat
);

    localparam int IW = $clog2(SEGMENTS + 1);
    localparam int RW = $clog2(2 * SEGMENTS) + 1;
    localparam logic [T_W-1:0] TQ = T_W'(65536 / SEGMENTS);
    localparam logic [RW-1:0]  TR = RW'(65536 % SEGMENTS);
    localparam logic [RW-1:0]  R0 = RW'(SEGMENTS / 2);
    localparam logic [RW-1:0]  SEG_R = RW'(SEGMENTS);
    localparam logic [IW-1:0]  SEG_I = IW'(SEGMENTS);

    logic en;
    assign en = !o_valid || i_ready;

    // sequencer
    logic           r_busy;
    logic [IW-1:0]  r_idx;
    logic [T_W-1:0] r_q;
    logic [RW-1:0]  r_r;
    t_item          r_item;
    logic [IW-1:0]  cur_idx;
    logic [T_W-1:0] cur_q, n_q;
    logic [RW-1:0]  cur_r, n_r, sum_r;
    logic           issue, last;
    t_item          cur_item;

    always_comb begin
        cur_idx  = r_busy ? r_idx : IW'(1);
        cur_q    = r_busy ? r_q : '0;
        cur_r    = r_busy ? r_r : R0;
        cur_item = r_busy ? r_item : i_q_item;
        sum_r    = cur_r + TR;
        if (sum_r >= SEG_R) begin
            n_r = sum_r - SEG_R;
            n_q = cur_q + TQ + T_W'(1);
        end else begin
            n_r = sum_r;
            n_q = cur_q + TQ;
        end
        if (n_q > T_ONE) begin
            n_q = T_ONE;
        end
        issue = en && (r_busy || i_q_valid);
        last  = cur_idx == SEG_I;
    end

    assign o_q_pop = en && !r_busy && i_q_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (issue) begin
            r_busy <= !last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_idx  <= cur_idx + IW'(1);
            r_q    <= n_q;
            r_r    <= n_r;
            r_item <= cur_item;
        end
    end

    // evaluation pipeline
    logic [10:1]    r_vld;
    t_tok           r_tk [1:8];
    logic [T_W-1:0] r_t1, r_u1, r_t2, r_u2;
    logic [33:0]    r_uu, r_tt;
    logic [49:0]    r_p0, r_p1, r_p2, r_p3;
    logic [WGT_W-1:0] r_w0, r_w1, r_w2, r_w3;
    logic [54:0]    r_mx0, r_mx1, r_mx2, r_mx3, r_my0, r_my1, r_my2, r_my3;
    logic [56:0]    r_sx, r_sy;
    logic [PNT_W-1:0] r_x, r_y, r_px, r_py, r_dx, r_dy, prev_x, prev_y;
    logic [53:0]    r_dxx, r_dyy;
    logic [SQ_W-1:0] r_s;
    logic           r_lst10;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[9:1], issue};
        end
    end

    always_comb begin
        prev_x = r_tk[7].first ? PNT_W'(r_tk[7].item.ox) : r_px;
        prev_y = r_tk[7].first ? PNT_W'(r_tk[7].item.oy) : r_py;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_tk[1] <= '{item: cur_item, first: !r_busy, last: last};
            r_t1    <= n_q;
            r_u1    <= T_ONE - n_q;
            for (int k = 2; k <= 8; k++) begin
                r_tk[k] <= r_tk[k-1];
            end
            r_t2  <= r_t1;
            r_u2  <= r_u1;
            r_uu  <= r_u1 * r_u1;
            r_tt  <= r_t1 * r_t1;
            r_p0  <= 50'(r_uu * r_u2);
            r_p1  <= 50'(r_uu * r_t2);
            r_p2  <= 50'(r_tt * r_u2);
            r_p3  <= 50'(r_tt * r_t2);
            r_w0  <= WGT_W'((r_p0 + 50'h20000) >> 18);
            r_w1  <= WGT_W'((r_p1 + (r_p1 << 1) + 50'h20000) >> 18);
            r_w2  <= WGT_W'((r_p2 + (r_p2 << 1) + 50'h20000) >> 18);
            r_w3  <= WGT_W'((r_p3 + 50'h20000) >> 18);
            r_mx0 <= r_w0 * r_tk[4].item.ox;
            r_mx1 <= r_w1 * r_tk[4].item.cx;
            r_mx2 <= r_w2 * r_tk[4].item.cx;
            r_mx3 <= r_w3 * r_tk[4].item.tx;
            r_my0 <= r_w0 * r_tk[4].item.oy;
            r_my1 <= r_w1 * r_tk[4].item.oy;
            r_my2 <= r_w2 * r_tk[4].item.ty;
            r_my3 <= r_w3 * r_tk[4].item.ty;
            r_sx  <= 57'(r_mx0) + 57'(r_mx1) + 57'(r_mx2) + 57'(r_mx3);
            r_sy  <= 57'(r_my0) + 57'(r_my1) + 57'(r_my2) + 57'(r_my3);
            r_x   <= PNT_W'((r_sx + 57'h2000_0000) >> 30);
            r_y   <= PNT_W'((r_sy + 57'h2000_0000) >> 30);
            r_dx  <= (r_x > prev_x) ? r_x - prev_x : prev_x - r_x;
            r_dy  <= (r_y > prev_y) ? r_y - prev_y : prev_y - r_y;
            if (r_vld[7]) begin
                r_px <= r_x;
                r_py <= r_y;
            end
            r_dxx   <= r_dx * r_dx;
            r_dyy   <= r_dy * r_dy;
            r_s     <= SQ_W'(r_dxx) + SQ_W'(r_dyy);
            r_lst10 <= r_lst9;
        end
    end

    logic            r_lst9;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_lst9 <= r_tk[8].last;
        end
    end

    logic            sq_valid, sq_last;
    logic [RT_W-1:0] sq_root;

    cbal_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_vld[10]),
        .i_last  (r_lst10),
        .i_val   (r_s),
        .o_valid (sq_valid),
        .o_last  (sq_last),
        .o_root  (sq_root)
    );

    // accumulate and present
    logic [ACC_W-1:0] r_acc, acc_sum;
    logic             r_ovalid;
    logic [LEN_W-1:0] r_len;
    logic             r_sat;

    assign acc_sum = r_acc + ACC_W'(sq_root);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (en && sq_valid) begin
                r_acc <= sq_last ? '0 : acc_sum;
            end
            if (en) begin
                r_ovalid <= sq_valid && sq_last;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && sq_valid && sq_last) begin
            r_sat <= acc_sum >= LEN_MAX;
            r_len <= (acc_sum >= LEN_MAX) ? LEN_MAX[LEN_W-1:0] : acc_sum[LEN_W-1:0];
        end
    end

    assign o_valid = r_ovalid;
    assign o_len   = r_len;
    assign o_sat   = r_sat;

endmodule

// File: verif/cbal_checker.sv
// Checker for the cubic Bezier arc length unit: watches both stream channels,
// predicts each curve length from the input transfer and compares results.
// Depends on nothing beyond the block's port widths.
`timescale 1ns / 1ps

module cbal_checker #(
    parameter int SEGMENTS = 100
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [95:0] i_in_data,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [31:0] i_out_data,
    input  logic        i_out_sat,
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct packed {
        logic [31:0] length;
        logic        sat;
    } t_length;

    t_length lengths_due[$];

    function automatic logic [63:0] round_sqrt(input logic [63:0] s);
        logic [63:0] r;
        logic [63:0] b;
        logic [63:0] v;
        r = 0;
        b = 64'd1 << 62;
        v = s;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        if (s - r * r > r) r = r + 1;
        return r;
    endfunction

    function automatic t_length curve_length(input logic [95:0] d);
        logic [63:0] ox, oy, tx, ty, cx, px, py, sum, segs, t, u, x, y, dx, dy;
        logic [63:0] w0, w1, w2, w3;
        t_length res;
        segs = (SEGMENTS < 1) ? 64'd1 : 64'(SEGMENTS);
        ox = {40'd0, d[23:0] ^ 24'h800000};
        oy = {40'd0, d[47:24] ^ 24'h800000};
        tx = {40'd0, d[71:48] ^ 24'h800000};
        ty = {40'd0, d[95:72] ^ 24'h800000};
        cx = (ox + tx) >> 1;
        px = ox;
        py = oy;
        sum = 0;
        for (longint i = 1; i <= longint'(segs); i++) begin
            t = (64'(i) * 64'd65536 + (segs >> 1)) / segs;
            if (t > 64'd65536) t = 64'd65536;
            u = 64'd65536 - t;
            w0 = (u * u * u + (64'd1 << 17)) >> 18;
            w1 = (64'd3 * u * u * t + (64'd1 << 17)) >> 18;
            w2 = (64'd3 * u * t * t + (64'd1 << 17)) >> 18;
            w3 = (t * t * t + (64'd1 << 17)) >> 18;
            x = (w0 * ox + w1 * cx + w2 * cx + w3 * tx + (64'd1 << 29)) >> 30;
            y = (w0 * oy + w1 * oy + w2 * ty + w3 * ty + (64'd1 << 29)) >> 30;
            dx = (x > px) ? x - px : px - x;
            dy = (y > py) ? y - py : py - y;
            sum = sum + round_sqrt(dx * dx + dy * dy);
            px = x;
            py = y;
        end
        if (sum >= 64'hFFFF_FFFF) begin
            res.length = 32'hFFFF_FFFF;
            res.sat = 1'b1;
        end else begin
            res.length = sum[31:0];
            res.sat = 1'b0;
        end
        return res;
    endfunction

    assign o_pending = lengths_due.size();

    initial o_fail_count = 0;

    always @(posedge i_clk) begin
        t_length due;
        int      errs;
        errs = 0;
        if (i_rst_n && i_in_valid && i_in_ready) begin
            lengths_due.push_back(curve_length(i_in_data));
        end
        if (i_rst_n && i_out_valid && i_out_ready) begin
            if (lengths_due.size() == 0) begin
                $error("unexpected result transfer: length %0h", i_out_data);
                errs = errs + 1;
            end else begin
                due = lengths_due.pop_front();
                if (i_out_data !== due.length) begin
                    $error("curve_length: expected %0h, actual %0h", due.length, i_out_data);
                    errs = errs + 1;
                end
                if (i_out_sat !== due.sat) begin
                    $error("length_saturated: expected %0b, actual %0b", due.sat, i_out_sat);
                    errs = errs + 1;
                end
            end
        end
        if (errs != 0) begin
            o_fail_count <= o_fail_count + errs;
        end
    end

endmodule

// File: verif/cubic_bezier_arc_length_unit_tb.sv
// Testbench top for the cubic Bezier arc length unit: drives curves with random
// gaps and stalls, and gives the verdict from the checker's failure count.
// Depends on cubic_bezier_arc_length_unit and cbal_checker.
`timescale 1ns / 1ps

module cubic_bezier_arc_length_unit_tb;

    localparam int SEGMENTS = 100;
    localparam int N_RANDOM = 1830;
    localparam int LATENCY  = SEGMENTS + 44;
    localparam longint CYCLE_LIMIT = 64'd3_000_000;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [95:0] s_axis_tdata;   // origin_x, origin_y, target_x, target_y
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;   // curve_length
    logic        m_axis_tuser;   // length_saturated
    int          fail_count;
    int          pending;
    longint      cycles;
    logic        stall_long;

    cubic_bezier_arc_length_unit #(.SEGMENTS(SEGMENTS)) DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
    );

    cbal_checker #(.SEGMENTS(SEGMENTS)) u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(s_axis_tvalid), .i_in_ready(s_axis_tready), .i_in_data(s_axis_tdata),
        .i_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .i_out_data(m_axis_tdata), .i_out_sat(m_axis_tuser),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles = cycles + 1;
            if (cycles > CYCLE_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    function automatic int gap_len();
        if ($urandom_range(0, 19) == 0) return $urandom_range(20, 300);
        if ($urandom_range(0, 2) == 0) return 0;
        return $urandom_range(0, 4);
    endfunction

    function automatic logic [23:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 24'h7FFFFF - 24'($urandom_range(0, 3));
            1: return 24'h800000 + 24'($urandom_range(0, 3));
            2: return 24'($signed($urandom_range(0, 4000)) - 2000);
            default: return 24'($urandom);
        endcase
    endfunction

    // receiver: random stalls, plus one long hold-off early in the random part
    initial begin
        m_axis_tready = 1'b0;
        @(negedge i_clk);
        forever begin
            if (stall_long) begin
                m_axis_tready <= 1'b0;
                repeat (3000) @(negedge i_clk);
                stall_long = 1'b0;
            end
            if ($urandom_range(0, 3) == 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap_len()) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 60)) @(negedge i_clk);
        end
    end

    task automatic send_curve(input logic [23:0] ox, input logic [23:0] oy,
                              input logic [23:0] tx, input logic [23:0] ty);
        int g;
        g = gap_len();
        if (g > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (g) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {ty, tx, oy, ox};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    initial begin
        logic [23:0] mx, mn, z;
        mx = 24'h7FFFFF;
        mn = 24'h800000;
        z  = 24'd0;
        stall_long = 1'b0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;
        // extremes, coincident points, saturation
        send_curve(z, z, z, z);
        send_curve(mx, mx, mx, mx);
        send_curve(mn, mn, mn, mn);
        send_curve(mn, mn, mx, mx);
        send_curve(mx, mx, mn, mn);
        send_curve(mn, mx, mx, mn);
        send_curve(mx, mn, mn, mx);
        send_curve(mn, z, mx, z);
        send_curve(z, mn, z, mx);
        send_curve(z, z, 24'd256, z);
        send_curve(z, z, z, 24'd256);
        send_curve(z, z, 24'd1, 24'd1);
        send_curve(24'hFFFFFF, 24'hFFFFFF, 24'd1, 24'd1);
        send_curve(24'h555555, 24'hAAAAAA, 24'hAAAAAA, 24'h555555);
        send_curve(24'h123456, 24'h123456, 24'h123456, 24'h123456);
        stall_long = 1'b1;
        for (int n = 0; n < N_RANDOM; n++) begin
            send_curve(rand_coord(), rand_coord(), rand_coord(), rand_coord());
        end
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (LATENCY + 20) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
